// ===== rtl/core/gra_pkg.sv =====
`timescale 1ns / 1ps

package gra_pkg;

    localparam int DIM_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] ATLAS_RESET = 13'd1024;

    // Input modes
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RESTART = 1'b1;

    // Commands broadcast to every cell of the chain
    localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_FIT    = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd4;

    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } t_rect;

    typedef struct packed {
        logic  valid;
        t_rect rect;
    } t_link;

    // For OP_FIT, rect.w and rect.h carry the request size
    typedef struct packed {
        logic [OP_W-1:0] op;
        t_rect           rect;
    } t_cell_cmd;

    typedef struct packed {
        logic             mode;
        logic [DIM_W-1:0] req_width;
        logic [DIM_W-1:0] req_height;
    } t_in_item;

    typedef struct packed {
        logic             placed;
        logic [DIM_W-1:0] out_x;
        logic [DIM_W-1:0] out_y;
        logic [DIM_W-1:0] out_width;
        logic [DIM_W-1:0] out_height;
        logic             list_overflow;
    } t_out_item;

endpackage

// ===== rtl/core/gra_cell.sv =====
`timescale 1ns / 1ps

module gra_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gra_pkg::t_cell_cmd i_cmd,
    input  gra_pkg::t_link    i_prev,
    input  logic              i_prev_lt,
    input  logic              i_prev_prefix,
    input  gra_pkg::t_link    i_next,
    output gra_pkg::t_link    o_link,
    output logic              o_lt,
    output logic              o_prefix,
    output gra_pkg::t_rect    o_sel
);

    logic          r_valid;
    logic          r_fit;
    gra_pkg::t_rect r_rect;

    logic w_lt;
    logic w_shift_up;

    assign w_lt       = r_valid && (r_rect.h < i_cmd.rect.h);
    assign w_shift_up = i_prev_prefix | r_fit;

    assign o_link.valid = r_valid;
    assign o_link.rect  = r_rect;
    assign o_lt         = w_lt;
    assign o_prefix     = w_shift_up;
    assign o_sel        = (r_fit && !i_prev_prefix) ? r_rect : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_fit   <= 1'b0;
        end else begin
            case (i_cmd.op)
                gra_pkg::OP_CLEAR: begin
                    r_valid <= 1'b0;
                end
                gra_pkg::OP_FIT: begin
                    r_fit <= r_valid && (r_rect.w >= i_cmd.rect.w) &&
                             (r_rect.h >= i_cmd.rect.h);
                end
                gra_pkg::OP_REMOVE: begin
                    // close the gap left by the first fitting entry
                    if (w_shift_up) begin
                        r_valid <= i_next.valid;
                        r_rect  <= i_next.rect;
                    end
                    r_fit <= 1'b0;
                end
                gra_pkg::OP_INSERT: begin
                    // entries of lower height hold, the slot after them takes
                    // the new rectangle, the rest move up by one
                    if (!w_lt) begin
                        if (i_prev_lt) begin
                            r_valid <= 1'b1;
                            r_rect  <= i_cmd.rect;
                        end else begin
                            r_valid <= i_prev.valid;
                            r_rect  <= i_prev.rect;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/gra_chain.sv =====
`timescale 1ns / 1ps

module gra_chain #(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gra_pkg::t_cell_cmd i_cmd,
    output gra_pkg::t_rect     o_sel,
    output logic               o_found,
    output logic               o_full
);

    gra_pkg::t_link w_link   [DEPTH];
    logic           w_lt     [DEPTH];
    logic           w_prefix [DEPTH];
    gra_pkg::t_rect w_sel    [DEPTH];

    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        gra_pkg::t_link w_prev;
        gra_pkg::t_link w_next;
        logic           w_prev_lt;
        logic           w_prev_prefix;

        if (j == 0) begin : g_head
            assign w_prev        = '0;
            assign w_prev_lt     = 1'b1;
            assign w_prev_prefix = 1'b0;
        end else begin : g_body
            assign w_prev        = w_link[j-1];
            assign w_prev_lt     = w_lt[j-1];
            assign w_prev_prefix = w_prefix[j-1];
        end

        if (j == DEPTH - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_link[j+1];
        end

        gra_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (i_cmd),
            .i_prev       (w_prev),
            .i_prev_lt    (w_prev_lt),
            .i_prev_prefix(w_prev_prefix),
            .i_next       (w_next),
            .o_link       (w_link[j]),
            .o_lt         (w_lt[j]),
            .o_prefix     (w_prefix[j]),
            .o_sel        (w_sel[j])
        );
    end

    // at most one cell drives a nonzero selection
    always_comb begin
        o_sel = '0;
        for (int j = 0; j < DEPTH; j++) begin
            o_sel = o_sel | w_sel[j];
        end
    end

    assign o_found = w_prefix[DEPTH-1];
    assign o_full  = w_link[DEPTH-1].valid;

endmodule

// ===== rtl/core/guillotine_rect_allocator.sv =====
`timescale 1ns / 1ps

// Guillotine rectangle allocator for a 2D atlas. The free list lives in a row
// of FREE_DEPTH cells kept sorted by ascending height; each cell holds one free
// rectangle and trades it with its neighbors to remove or insert an entry with a
// single command. An allocate transaction runs from acceptance to the result
// through fit check, removal, split, two sorted inserts and output load, or
// through fit check, removal attempt and output load when nothing fits; a
// restart runs clear, atlas insert, empty bottom slot and output load. A
// sequencer steps the cell row through these commands one at a time; a new
// transaction is taken the cycle after the previous one has reached the output
// register, and none is accepted while one is in progress. The output load
// waits while an earlier result is still unaccepted. Configuration writes are
// always ready and should be issued only while the block is idle. The list is
// empty after reset until a restart.
module guillotine_rect_allocator #(
    parameter int FREE_DEPTH = 64,
    parameter int MAX_DIM    = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  gra_pkg::t_in_item                 i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output gra_pkg::t_out_item                o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gra_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gra_pkg::DIM_W-1:0]         i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLR   = 3'd1;
    localparam logic [2:0] S_FIT   = 3'd2;
    localparam logic [2:0] S_TAKE  = 3'd3;
    localparam logic [2:0] S_SPLIT = 3'd4;
    localparam logic [2:0] S_INS_R = 3'd5;
    localparam logic [2:0] S_INS_B = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]                   r_state;
    logic [2:0]                   n_state;
    logic [gra_pkg::DIM_W-1:0]    r_atlas_w;
    logic [gra_pkg::DIM_W-1:0]    r_atlas_h;
    gra_pkg::t_in_item            r_req;
    gra_pkg::t_rect               r_sel;
    gra_pkg::t_rect               r_right;
    gra_pkg::t_rect               r_bottom;
    logic                         r_placed;
    logic                         r_ovf;
    gra_pkg::t_out_item           r_out;
    logic                         r_out_valid;

    gra_pkg::t_cell_cmd           w_cmd;
    gra_pkg::t_rect               w_chain_sel;
    logic                         w_found;
    logic                         w_full;
    logic                         w_in_acc;
    logic                         w_right_ok;
    logic                         w_bottom_ok;
    logic [gra_pkg::DIM_W-1:0]    w_aw_sat;
    logic [gra_pkg::DIM_W-1:0]    w_ah_sat;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_in_acc    = i_in_valid && o_in_ready;

    assign w_aw_sat = (32'(r_atlas_w) > 32'(MAX_DIM)) ? gra_pkg::DIM_W'(MAX_DIM) : r_atlas_w;
    assign w_ah_sat = (32'(r_atlas_h) > 32'(MAX_DIM)) ? gra_pkg::DIM_W'(MAX_DIM) : r_atlas_h;

    assign w_right_ok  = (r_right.w != '0) && (r_right.h != '0);
    assign w_bottom_ok = (r_bottom.w != '0) && (r_bottom.h != '0);

    gra_chain #(
        .DEPTH(FREE_DEPTH)
    ) u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .o_sel  (w_chain_sel),
        .o_found(w_found),
        .o_full (w_full)
    );

    always_comb begin
        w_cmd.op   = gra_pkg::OP_NONE;
        w_cmd.rect = r_right;
        n_state    = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_in.mode == gra_pkg::MODE_RESTART) ? S_CLR : S_FIT;
                end
            end
            S_CLR: begin
                w_cmd.op = gra_pkg::OP_CLEAR;
                n_state  = S_INS_R;
            end
            S_FIT: begin
                w_cmd.op     = gra_pkg::OP_FIT;
                w_cmd.rect   = '0;
                w_cmd.rect.w = r_req.req_width;
                w_cmd.rect.h = r_req.req_height;
                n_state      = S_TAKE;
            end
            S_TAKE: begin
                w_cmd.op = gra_pkg::OP_REMOVE;
                n_state  = w_found ? S_SPLIT : S_DONE;
            end
            S_SPLIT: begin
                n_state = S_INS_R;
            end
            S_INS_R: begin
                if (w_right_ok && !w_full) begin
                    w_cmd.op = gra_pkg::OP_INSERT;
                end
                n_state = S_INS_B;
            end
            S_INS_B: begin
                w_cmd.rect = r_bottom;
                if (w_bottom_ok && !w_full) begin
                    w_cmd.op = gra_pkg::OP_INSERT;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_atlas_w   <= gra_pkg::ATLAS_RESET;
            r_atlas_h   <= gra_pkg::ATLAS_RESET;
            r_out_valid <= 1'b0;
            r_placed    <= 1'b0;
            r_ovf       <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    gra_pkg::CFG_ATLAS_WIDTH:  r_atlas_w <= i_cfg_data;
                    gra_pkg::CFG_ATLAS_HEIGHT: r_atlas_h <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // in S_DONE the output load below decides the valid flag
            if (o_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_req    <= i_in;
                        r_placed <= 1'b0;
                        r_ovf    <= 1'b0;
                    end
                end
                S_CLR: begin
                    // the atlas rectangle goes in through the right-remainder slot
                    r_right   <= '{x: '0, y: '0, w: w_aw_sat, h: w_ah_sat};
                    r_bottom  <= '0;
                end
                S_TAKE: begin
                    r_sel    <= w_chain_sel;
                    r_placed <= w_found;
                end
                S_SPLIT: begin
                    r_right.x  <= r_sel.x + r_req.req_width;
                    r_right.y  <= r_sel.y;
                    r_right.w  <= r_sel.w - r_req.req_width;
                    r_right.h  <= r_req.req_height;
                    r_bottom.x <= r_sel.x;
                    r_bottom.y <= r_sel.y + r_req.req_height;
                    r_bottom.w <= r_sel.w;
                    r_bottom.h <= r_sel.h - r_req.req_height;
                end
                S_INS_R: begin
                    if (w_right_ok && w_full) begin
                        r_ovf <= 1'b1;
                    end
                end
                S_INS_B: begin
                    if (w_bottom_ok && w_full) begin
                        r_ovf <= 1'b1;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        if (r_placed) begin
                            r_out.placed        <= 1'b1;
                            r_out.out_x         <= r_sel.x;
                            r_out.out_y         <= r_sel.y;
                            r_out.out_width     <= r_req.req_width;
                            r_out.out_height    <= r_req.req_height;
                            r_out.list_overflow <= r_ovf;
                        end else begin
                            r_out <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
